// ----- rtl/core/mnvs_pkg.sv -----
// Package for the midpoint nearest-vector search block.
// Field structs, actions, default sizes. No dependencies.
package mnvs_pkg;
  localparam int ENTRIES_DEF = 256;
  localparam int DIMS_DEF = 16;
  localparam int ELEM_BITS_DEF = 16;
  localparam int DIST_W = 38;
  localparam int CONF_W = 16;

  localparam logic [1:0] ACT_WR_ELEM = 2'd0;
  localparam logic [1:0] ACT_WR_ACTIVE = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] entry_index;
    logic [3:0] dim_index;
    logic [15:0] element_value;
    logic active_value;
    logic [15:0] first_id;
    logic [15:0] second_id;
  } cmd_t;

  typedef struct packed {
    logic ids_valid;
    logic found;
    logic [7:0] nearest_index;
    logic [DIST_W-1:0] best_distance;
    logic [CONF_W-1:0] confidence;
  } res_t;
endpackage

// ----- rtl/core/mnvs_ram.sv -----
// Generic single-port-write, one-read synchronous RAM, registered read.
// No dependencies.
module mnvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/midpoint_nearest_vector_search.sv -----
// Top level of the midpoint nearest-vector search.
// Depends on mnvs_pkg and mnvs_ram (row-wide vector memory, one-bit active memory).
//
//  channel | signals                          | transfer when
//  cmd     | start, busy, cmd                 | start && !busy
//  result  | res_valid, res                   | res_valid (one cycle)
//  config  | cfg_valid, cfg_ready, cfg_data   | cfg_valid && cfg_ready
//
// Element write: busy after the transfer (row read, write back). Active-bit
// write: busy stays low. Query: busy while both rows are read, the entries
// below the count are scanned and the divider runs; the scan is skipped with
// invalid ids and the divider with no active entry. The result strobe comes
// in the first cycle with busy low. After reset a busy clearing pass zeroes the
// active bits; the vector memory is not cleared. Results cannot be stalled.
module midpoint_nearest_vector_search
  import mnvs_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int DIMS = DIMS_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  mnvs_pkg::cmd_t cmd,
  output logic res_valid,
  output mnvs_pkg::res_t res,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [8:0] cfg_data
);
  localparam int EW = $clog2(ENTRIES);
  localparam int DWI = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int ROW_W = DIMS * ELEM_BITS;
  localparam int CW = EW + 1;
  localparam int SQ_W = 2 * (ELEM_BITS + 2);
  localparam int ACC_W = 64;
  localparam logic [ACC_W-1:0] FS = ACC_W'((64'd1 << ELEM_BITS) - 64'd1);
  localparam logic [ACC_W-1:0] KC = ACC_W'(4) * FS * FS;
  localparam int QBITS = 16;
  localparam int NUM_W = ACC_W + QBITS;
  // 65535 * K, split into the starting remainder and the bits fed serially
  localparam logic [NUM_W-1:0] NUM = (NUM_W'(KC) << QBITS) - NUM_W'(KC);
  localparam logic [ACC_W-1:0] NUM_HI = NUM[NUM_W-1:QBITS];
  localparam logic [QBITS-1:0] NUM_LO = NUM[QBITS-1:0];

  localparam logic [3:0] S_IDLE = 4'd0, S_WRRD = 4'd1, S_WRWB = 4'd2,
                         S_RA = 4'd3, S_RB = 4'd4, S_MID = 4'd5,
                         S_SCAN = 4'd6, S_SQ = 4'd7, S_SUM = 4'd8,
                         S_CMP = 4'd9, S_DIV = 4'd10, S_DONE = 4'd11,
                         S_CLR = 4'd12;

  logic [3:0] state;
  cmd_t c;
  logic [8:0] entry_count;
  logic [CW-1:0] count, idx;
  logic [EW-1:0] raddr;
  logic we;
  logic [EW-1:0] waddr;
  logic [ROW_W-1:0] wdata, rdata;
  logic act_we;
  logic [EW-1:0] act_waddr;
  logic [0:0] act_wdata, act_rdata;
  logic cur_act;
  logic [ROW_W+DIMS-1:0] mid;  // a+b per dim
  logic [DIMS-1:0][SQ_W-1:0] sq;
  logic [ACC_W-1:0] best;
  logic [EW-1:0] best_idx;
  logic found, valid;
  logic [ACC_W-1:0] den, rem;
  logic [QBITS-1:0] q, nbits;
  logic [4:0] qcnt;
  logic [ACC_W-1:0] sum_c;

  mnvs_ram #(.WIDTH(ROW_W), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata));

  mnvs_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_act (
    .clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
    .raddr(raddr), .rdata(act_rdata));

  assign count = (32'(entry_count) > ENTRIES) ? CW'(ENTRIES) : CW'(entry_count);
  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  always_comb begin
    sum_c = '0;
    for (int k = 0; k < DIMS; k++) sum_c = sum_c + ACC_W'(sq[k]);
  end

  always_comb begin
    wdata = rdata;
    wdata[DWI'(c.dim_index)*ELEM_BITS +: ELEM_BITS] = ELEM_BITS'(c.element_value);
  end

  always_ff @(posedge clk) begin
    we <= 1'b0;
    act_we <= 1'b0;
    res_valid <= 1'b0;
    if (rst) begin
      state <= S_CLR;
      entry_count <= '0;
      idx <= '0;
    end else begin
      case (state)
        S_CLR: begin
          act_we <= 1'b1;
          act_waddr <= idx[EW-1:0];
          act_wdata <= 1'b0;
          idx <= idx + 1'b1;
          if (idx == CW'(ENTRIES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_valid && cfg_ready) entry_count <= cfg_data;
          if (start) begin
            c <= cmd;
            raddr <= EW'(cmd.entry_index);
            case (cmd.action)
              ACT_WR_ELEM: if (32'(cmd.entry_index) < ENTRIES &&
                               32'(cmd.dim_index) < DIMS) state <= S_WRRD;
              ACT_WR_ACTIVE: if (32'(cmd.entry_index) < ENTRIES) begin
                act_we <= 1'b1;
                act_waddr <= EW'(cmd.entry_index);
                act_wdata <= cmd.active_value;
              end
              ACT_QUERY: begin
                raddr <= cmd.first_id[EW-1:0];
                state <= S_RA;
              end
              default: ;
            endcase
          end
        end
        S_WRRD: state <= S_WRWB;
        S_WRWB: begin
          we <= 1'b1;
          waddr <= EW'(c.entry_index);
          state <= S_IDLE;
        end
        S_RA: begin
          valid <= 32'(c.first_id) < 32'(count) && 32'(c.second_id) < 32'(count);
          raddr <= c.second_id[EW-1:0];
          state <= S_RB;
        end
        S_RB: begin
          for (int k = 0; k < DIMS; k++)
            mid[k*(ELEM_BITS+1) +: ELEM_BITS+1] <=
              (ELEM_BITS+1)'(rdata[k*ELEM_BITS +: ELEM_BITS]);
          state <= S_MID;
        end
        S_MID: begin
          for (int k = 0; k < DIMS; k++)
            mid[k*(ELEM_BITS+1) +: ELEM_BITS+1] <= mid[k*(ELEM_BITS+1) +: ELEM_BITS+1]
              + (ELEM_BITS+1)'(rdata[k*ELEM_BITS +: ELEM_BITS]);
          found <= 1'b0;
          best <= '0;
          best_idx <= '0;
          idx <= '0;
          if (!valid) state <= S_DONE;
          else state <= S_SCAN;
        end
        S_SCAN: begin
          if (idx >= count) begin
            den <= KC + ACC_W'(10) * best;
            rem <= NUM_HI;
            nbits <= NUM_LO;
            q <= '0;
            qcnt <= '0;
            state <= found ? S_DIV : S_DONE;
          end else begin
            raddr <= idx[EW-1:0];
            state <= S_SQ;
          end
        end
        S_SQ: state <= S_SUM;
        S_SUM: begin
          for (int k = 0; k < DIMS; k++) begin
            logic [ELEM_BITS+1:0] s, t, d;
            s = (ELEM_BITS+2)'(mid[k*(ELEM_BITS+1) +: ELEM_BITS+1]);
            t = {1'b0, rdata[k*ELEM_BITS +: ELEM_BITS], 1'b0};
            d = (s >= t) ? s - t : t - s;
            sq[k] <= SQ_W'(d) * SQ_W'(d);
          end
          cur_act <= act_rdata[0];
          state <= S_CMP;
        end
        S_CMP: begin
          if (cur_act && (!found || sum_c < best)) begin
            found <= 1'b1;
            best <= sum_c;
            best_idx <= idx[EW-1:0];
          end
          idx <= idx + 1'b1;
          state <= S_SCAN;
        end
        S_DIV: begin
          // restoring division of 65535*K by den, low numerator bits fed serially
          logic [ACC_W-1:0] r1;
          r1 = {rem[ACC_W-2:0], nbits[QBITS-1]};
          if (r1 >= den) begin
            rem <= r1 - den;
            q <= {q[QBITS-2:0], 1'b1};
          end else begin
            rem <= r1;
            q <= {q[QBITS-2:0], 1'b0};
          end
          nbits <= {nbits[QBITS-2:0], 1'b0};
          qcnt <= qcnt + 1'b1;
          if (qcnt == 5'(QBITS-1)) state <= S_DONE;
        end
        S_DONE: begin
          res_valid <= 1'b1;
          res.ids_valid <= valid;
          res.found <= valid && found;
          res.nearest_index <= (valid && found) ? 8'(best_idx) : 8'd0;
          res.best_distance <= (valid && found) ? best[DIST_W-1:0] : '0;
          res.confidence <= (valid && found) ? q : '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_res: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !busy) else $error("result while busy");
  a_found_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.found |-> res.ids_valid) else $error("found without valid ids");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> state == S_IDLE) else $error("config taken while busy");
`endif
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for midpoint_nearest_vector_search: table loads,
// active bits, blend queries over several entry counts, random start idling.
// Depends on mnvs_pkg and the RTL of the block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mnvs_pkg::*;

  localparam int N_ENT = 256;
  localparam int N_DIM = 16;

  class search_scoreboard;
    bit [15:0] vectors [N_ENT][N_DIM];
    bit active [N_ENT];
    int unsigned entry_count;
    res_t pending [$];
    int errors;

    function new();
      entry_count = 0;
      errors = 0;
      foreach (active[i]) active[i] = 0;
    endfunction

    function void set_count(bit [8:0] v);
      entry_count = v;
    endfunction

    function void note_cmd(cmd_t c);
      res_t r;
      int unsigned cnt;
      longint unsigned sum_sq, low_sum, k, s, t, d;
      bit hit;
      cnt = entry_count < N_ENT ? entry_count : N_ENT;
      case (c.action)
        ACT_WR_ELEM: vectors[c.entry_index][c.dim_index] = c.element_value;
        ACT_WR_ACTIVE: active[c.entry_index] = c.active_value;
        ACT_QUERY: begin
          r = '0;
          if (c.first_id < cnt && c.second_id < cnt) begin
            r.ids_valid = 1;
            hit = 0;
            low_sum = 0;
            for (int i = 0; i < cnt; i++) begin
              if (!active[i]) continue;
              sum_sq = 0;
              for (int j = 0; j < N_DIM; j++) begin
                s = longint'(vectors[c.first_id][j]) + longint'(vectors[c.second_id][j]);
                t = 2 * longint'(vectors[i][j]);
                d = s >= t ? s - t : t - s;
                sum_sq += d * d;
              end
              if (!hit || sum_sq < low_sum) begin
                hit = 1;
                low_sum = sum_sq;
                r.nearest_index = i[7:0];
              end
            end
            if (hit) begin
              k = 4 * 64'd65535 * 64'd65535;
              r.found = 1;
              r.best_distance = low_sum[DIST_W-1:0];
              r.confidence = 16'((64'd65535 * k) / (k + 10 * low_sum));
            end
          end
          pending.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(res_t r);
      res_t e;
      if (pending.size() == 0) begin
        $error("result with none expected: %p", r);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r.ids_valid !== e.ids_valid) begin
        $error("ids_valid exp %0d got %0d", e.ids_valid, r.ids_valid);
        errors++;
      end
      if (r.found !== e.found) begin
        $error("found exp %0d got %0d", e.found, r.found);
        errors++;
      end
      if (r.nearest_index !== e.nearest_index) begin
        $error("nearest_index exp %0d got %0d", e.nearest_index, r.nearest_index);
        errors++;
      end
      if (r.best_distance !== e.best_distance) begin
        $error("best_distance exp %0d got %0d", e.best_distance, r.best_distance);
        errors++;
      end
      if (r.confidence !== e.confidence) begin
        $error("confidence exp %0d got %0d", e.confidence, r.confidence);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, res_valid, cfg_valid, cfg_ready;
  cmd_t cmd;
  res_t res;
  logic [8:0] cfg_data;

  search_scoreboard sb;
  bit loaded [N_ENT];
  int n_sent;
  int idle_pct;

  midpoint_nearest_vector_search dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .res_valid(res_valid), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && res_valid) sb.check_result(res);
  end

  task automatic send(cmd_t c);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1;
    cmd <= c;
    do @(posedge clk); while (busy);
    sb.note_cmd(c);
    n_sent++;
    idle_pct = (n_sent > 500 && n_sent < 700) ? 0 : 28;
  endtask

  function automatic cmd_t noise_cmd();
    logic [63:0] raw;
    cmd_t c;
    raw = {$urandom, $urandom};
    c = raw[$bits(cmd_t)-1:0];
    return c;
  endfunction

  task automatic put_elem(bit [7:0] e, bit [3:0] dm, bit [15:0] v);
    cmd_t c;
    c = noise_cmd();
    c.action = ACT_WR_ELEM;
    c.entry_index = e;
    c.dim_index = dm;
    c.element_value = v;
    send(c);
  endtask

  task automatic put_active(bit [7:0] e, bit a);
    cmd_t c;
    c = noise_cmd();
    c.action = ACT_WR_ACTIVE;
    c.entry_index = e;
    c.active_value = a;
    send(c);
  endtask

  task automatic query(bit [15:0] a, bit [15:0] b);
    cmd_t c;
    c = noise_cmd();
    c.action = ACT_QUERY;
    c.first_id = a;
    c.second_id = b;
    send(c);
  endtask

  // mode 0 random, 1 all same value, 2 copy of src
  task automatic load_entry(bit [7:0] e, int mode, bit [15:0] v, bit [7:0] src, bit act);
    for (int j = 0; j < N_DIM; j++)
      put_elem(e, j[3:0], mode == 0 ? 16'($urandom) :
               mode == 1 ? v : sb.vectors[src][j]);
    loaded[e] = 1;
    put_active(e, act);
  endtask

  task automatic write_count(bit [8:0] v);
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (10) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_count(v);
  endtask

  function automatic int pick_loaded(int cnt);
    int idx [$];
    for (int i = 0; i < cnt; i++) if (loaded[i]) idx.push_back(i);
    if (idx.size() == 0) return -1;
    return idx[$urandom_range(idx.size() - 1)];
  endfunction

  task automatic random_phase(int n_items);
    int stop, roll, a, b, cnt;
    cmd_t c;
    stop = n_sent + n_items;
    while (n_sent < stop) begin
      cnt = sb.entry_count < N_ENT ? sb.entry_count : N_ENT;
      roll = $urandom_range(99);
      if (roll < 35) begin
        a = cnt > 0 && $urandom_range(3) != 0 ? $urandom_range(cnt - 1) : $urandom_range(255);
        b = pick_loaded(N_ENT);
        case ($urandom_range(5))
          0: load_entry(a[7:0], 1, $urandom_range(1) ? 16'hFFFF : 16'h0, 0, 1);
          1: if (b >= 0) load_entry(a[7:0], 2, 0, b[7:0], 1);
             else load_entry(a[7:0], 0, 0, 0, 1);
          default: load_entry(a[7:0], 0, 0, 0, $urandom_range(4) != 0);
        endcase
      end else if (roll < 75) begin
        a = pick_loaded(cnt);
        b = pick_loaded(cnt);
        if (a >= 0 && $urandom_range(9) != 0) query(a[15:0], b[15:0]);
        else begin
          a = $urandom_range(3) == 0 ? cnt : cnt + $urandom_range(65535 - cnt);
          b = $urandom_range(65535);
          if ($urandom_range(1)) query(a[15:0], b[15:0]);
          else query(b[15:0], a[15:0]);
        end
      end else if (roll < 85) begin
        put_elem(8'($urandom), 4'($urandom), 16'($urandom));
      end else if (roll < 95) begin
        a = $urandom_range(255);
        put_active(a[7:0], loaded[a] ? 1'($urandom_range(1)) : 1'b0);
      end else begin
        c = noise_cmd();
        c.action = 2'd3;
        send(c);
      end
    end
  endtask

  initial begin
    sb = new();
    n_sent = 0;
    idle_pct = 28;
    foreach (loaded[i]) loaded[i] = 0;
    rst = 1;
    start = 0;
    cmd = '0;
    cfg_valid = 0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // count is zero: every query has invalid ids
    query(0, 0);
    query(16'hFFFF, 16'hFFFF);
    put_active(8'd5, 0);
    load_entry(0, 1, 16'hFFFF, 0, 1);
    load_entry(1, 1, 16'h0000, 0, 1);
    load_entry(2, 2, 0, 1, 1);
    write_count(9'd256);
    query(0, 1);
    query(1, 2);
    query(0, 0);
    query(0, 16'd256);
    put_active(0, 0);
    put_active(1, 0);
    put_active(2, 0);
    query(0, 2);
    load_entry(8'd255, 1, 16'h8000, 0, 0);
    write_count(9'd511);
    query(16'd255, 0);
    query(1, 0);

    write_count(9'd1);
    random_phase(150);
    write_count(9'($urandom_range(2, 16)));
    random_phase(300);
    write_count(9'($urandom_range(17, 64)));
    random_phase(250);
    write_count(9'd256);
    random_phase(200);
    write_count(9'd0);
    random_phase(60);
    write_count(9'($urandom_range(257, 511)));
    random_phase(150);

    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule
